FILE: rtl/bpsk31_pkg.sv
// Package for the BPSK31 symbol modulator: sizes, config indexes, command
// struct, quarter-wave sine ROM contents and the phase-to-address helpers.
// No dependencies.
package bpsk31_pkg;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int PHASE_BITS       = 32;

    localparam int LOG2_DEPTH = $clog2(SINE_TABLE_DEPTH);
    localparam int IDX_W      = LOG2_DEPTH + 2;
    localparam int ADDR_W     = LOG2_DEPTH + 1;
    localparam int ROM_WORDS  = SINE_TABLE_DEPTH + 1;

    localparam logic [31:0] PHASE_MASK = 32'hFFFF_FFFF << (32 - PHASE_BITS);
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLES_PER_SYMBOL = 2'd0,
        CFG_CARRIER_STEP       = 2'd1,
        CFG_ENVELOPE_STEP      = 2'd2,
        CFG_AMPLITUDE          = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic accept;   // take the input item, update symbol state
        logic env_rd;   // ROM read of envelope cosine
        logic env_mul;  // form envelope, ROM read of carrier sine
        logic load;     // form sample into output register
    } t_cmd;

    typedef logic [14:0] t_rom [ROM_WORDS];

    function automatic logic [14:0] table_entry(input int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint unsigned r;
        x    = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 0; n < 7; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if ((n % 2) == 0) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        r = (longint'(sum) + 64'd16384) >> 15;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r[14:0];
    endfunction

    function automatic t_rom build_rom();
        t_rom t;
        for (int k = 0; k < ROM_WORDS; k++) begin
            t[k] = table_entry(k);
        end
        return t;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    // ROM address of a phase: quadrant 1 and 3 mirror the offset
    function automatic logic [ADDR_W-1:0] phase_addr(input logic [31:0] ph);
        logic [31:0]           masked;
        logic [IDX_W-1:0]      idx;
        logic [LOG2_DEPTH-1:0] w;
        masked = ph & PHASE_MASK;
        idx    = masked[31 -: IDX_W];
        w      = idx[LOG2_DEPTH-1:0];
        if (idx[IDX_W-2]) begin
            return ADDR_W'(SINE_TABLE_DEPTH) - {1'b0, w};
        end
        return {1'b0, w};
    endfunction

    // quadrants 2 and 3 are negative
    function automatic logic phase_neg(input logic [31:0] ph);
        logic [31:0] masked;
        masked = ph & PHASE_MASK;
        return masked[31];
    endfunction

endpackage

FILE: rtl/bpsk31_in_if.sv
// Input channel of the BPSK31 modulator: one item per audio sample tick.
// Standalone interface, no dependencies.
interface bpsk31_in_if;
    logic valid;
    logic ready;
    logic symbol_bit;
    logic message_start;

    modport source (output valid, output symbol_bit, output message_start, input ready);
    modport sink   (input valid, input symbol_bit, input message_start, output ready);
endinterface

FILE: rtl/bpsk31_out_if.sv
// Output channel of the BPSK31 modulator: one audio sample per item.
// Standalone interface, no dependencies.
interface bpsk31_out_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] sample;
    logic              symbol_end;

    modport source (output valid, output sample, output symbol_end, input ready);
    modport sink   (input valid, input sample, input symbol_end, output ready);
endinterface

FILE: rtl/bpsk31_symbol_modulator.sv
// BPSK31 symbol modulator top: sequencer plus datapath, item channels.
// Accept, envelope ROM read, envelope multiply with carrier ROM read, carrier
// multiply and load (waits on a full output). One item in flight, set by the
// single ROM port and two multiplies; a new item is taken while a result waits.
// Reset (synchronous, active low): config to defaults, phase/index cleared,
// latched bit 1, carrier sign positive, output empty.
module bpsk31_symbol_modulator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bpsk31_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bpsk31_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    bpsk31_in_if.sink                           i_sym,
    bpsk31_out_if.source                        o_smp
);
    bpsk31_pkg::t_cmd w_cmd;

    bpsk31_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sym.valid),
        .o_in_ready  (i_sym.ready),
        .o_out_valid (o_smp.valid),
        .i_out_ready (o_smp.ready),
        .o_cmd       (w_cmd)
    );

    bpsk31_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (w_cmd),
        .i_symbol_bit    (i_sym.symbol_bit),
        .i_message_start (i_sym.message_start),
        .o_sample        (o_smp.sample),
        .o_symbol_end    (o_smp.symbol_end)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sym.valid && i_sym.ready) |=> !i_sym.ready)
        else $error("input ready while item in flight");

    a_mul_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sym.valid && i_sym.ready) |-> ##2 w_cmd.env_mul)
        else $error("envelope multiply not two cycles after accept");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> o_smp.valid)
        else $error("output not valid after load");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> (!o_smp.valid || o_smp.ready))
        else $error("output overwritten before taken");

endmodule

FILE: rtl/bpsk31_ctrl.sv
// Sequencer of the BPSK31 modulator: accept, two ROM reads, two multiplies.
// Owns input ready and output valid. Depends on bpsk31_pkg.
module bpsk31_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output bpsk31_pkg::t_cmd  o_cmd
);
    typedef enum logic [1:0] {
        S_IDLE,
        S_ENV_RD,
        S_ENV_MUL,
        S_CAR_MUL
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;

    always_comb begin
        o_cmd        = '0;
        n_state      = r_state;
        n_out_valid  = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_ENV_RD;
                end
            end
            S_ENV_RD: begin
                o_cmd.env_rd = 1'b1;
                n_state      = S_ENV_MUL;
            end
            S_ENV_MUL: begin
                o_cmd.env_mul = 1'b1;
                n_state       = S_CAR_MUL;
            end
            S_CAR_MUL: begin
                if (w_out_free) begin
                    o_cmd.load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: rtl/bpsk31_dp.sv
// Datapath of the BPSK31 modulator: config registers, symbol state, sine ROM,
// envelope and carrier multipliers, output register. Depends on bpsk31_pkg.
module bpsk31_dp (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [bpsk31_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [bpsk31_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  bpsk31_pkg::t_cmd                        i_cmd,
    input  logic                                    i_symbol_bit,
    input  logic                                    i_message_start,
    output logic signed [15:0]                      o_sample,
    output logic                                    o_symbol_end
);
    logic [11:0] r_samples_per_symbol;
    logic [31:0] r_carrier_step;
    logic [31:0] r_envelope_step;
    logic [14:0] r_amplitude;

    logic [31:0] r_carrier_phase;
    logic [11:0] r_sample_index;
    logic [31:0] r_envelope_phase;
    logic        r_latched_bit;
    logic        r_carrier_negated;

    // per-item working registers
    logic [31:0] r_env_ph_use;
    logic        r_neg_use;
    logic        r_last;

    logic [14:0]        r_rom_q;
    logic               r_rom_neg;
    logic signed [15:0] r_env;
    logic signed [15:0] r_sample;
    logic               r_symbol_end;

    logic [11:0] w_idx0;
    logic        w_first;
    logic        w_bit;
    logic [31:0] w_ep;
    logic        w_neg;
    logic [11:0] w_n;
    logic [12:0] w_idx_inc;
    logic        w_last;
    logic [31:0] w_env_cos_ph;

    logic [bpsk31_pkg::ADDR_W-1:0] w_rd_addr;
    logic                          w_rd_neg;
    logic signed [15:0]            w_rom_val;
    logic signed [31:0]            w_env_prod;
    logic signed [31:0]            w_smp_prod;
    logic signed [15:0]            w_env_next;
    logic signed [15:0]            w_smp_next;

    // symbol bookkeeping at item accept
    assign w_idx0    = i_message_start ? 12'd0 : r_sample_index;
    assign w_first   = (w_idx0 == 12'd0);
    assign w_bit     = w_first ? i_symbol_bit : r_latched_bit;
    assign w_ep      = (i_message_start || w_first) ? 32'd0 : r_envelope_phase;
    assign w_neg     = i_message_start ? 1'b0 : r_carrier_negated;
    assign w_n       = (r_samples_per_symbol == 12'd0) ? 12'd1 : r_samples_per_symbol;
    assign w_idx_inc = {1'b0, w_idx0} + 13'd1;
    assign w_last    = (w_idx_inc >= {1'b0, w_n});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samples_per_symbol <= 12'd256;
            r_carrier_step       <= 32'd536870912;
            r_envelope_step      <= 32'd8388608;
            r_amplitude          <= 15'd20000;
        end else if (i_cfg_we) begin
            case (bpsk31_pkg::t_cfg_idx'(i_cfg_idx))
                bpsk31_pkg::CFG_SAMPLES_PER_SYMBOL: r_samples_per_symbol <= i_cfg_data[11:0];
                bpsk31_pkg::CFG_CARRIER_STEP:       r_carrier_step       <= i_cfg_data;
                bpsk31_pkg::CFG_ENVELOPE_STEP:      r_envelope_step      <= i_cfg_data;
                bpsk31_pkg::CFG_AMPLITUDE:          r_amplitude          <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carrier_phase   <= '0;
            r_sample_index    <= '0;
            r_envelope_phase  <= '0;
            r_latched_bit     <= 1'b1;
            r_carrier_negated <= 1'b0;
        end else if (i_cmd.accept) begin
            r_carrier_phase   <= r_carrier_phase + r_carrier_step;
            r_latched_bit     <= w_bit;
            r_carrier_negated <= w_neg ^ (w_last && !w_bit);
            if (w_last) begin
                r_sample_index   <= '0;
                r_envelope_phase <= '0;
            end else begin
                r_sample_index   <= w_idx_inc[11:0];
                r_envelope_phase <= w_ep + r_envelope_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_env_ph_use <= w_ep;
            r_neg_use    <= w_neg;
            r_last       <= w_last;
        end
    end

    // single-port sine ROM, registered read
    assign w_env_cos_ph = r_env_ph_use + bpsk31_pkg::QUARTER_TURN;
    assign w_rd_addr = i_cmd.env_rd ? bpsk31_pkg::phase_addr(w_env_cos_ph)
                                    : bpsk31_pkg::phase_addr(r_carrier_phase);
    assign w_rd_neg  = i_cmd.env_rd ? bpsk31_pkg::phase_neg(w_env_cos_ph)
                                    : bpsk31_pkg::phase_neg(r_carrier_phase);

    always_ff @(posedge i_clk) begin
        if (i_cmd.env_rd || i_cmd.env_mul) begin
            r_rom_q   <= bpsk31_pkg::SINE_ROM[w_rd_addr];
            r_rom_neg <= w_rd_neg;
        end
    end

    assign w_rom_val = r_rom_neg ? -$signed({1'b0, r_rom_q}) : $signed({1'b0, r_rom_q});

    // products truncated toward zero
    assign w_env_prod = $signed({1'b0, r_amplitude}) * w_rom_val;
    assign w_env_next = r_latched_bit ? $signed({1'b0, r_amplitude})
                      : (w_env_prod < 0) ? 16'((w_env_prod + 32'sd32767) >>> 15)
                                         : 16'(w_env_prod >>> 15);

    assign w_smp_prod = r_env * w_rom_val;
    assign w_smp_next = (w_smp_prod < 0) ? 16'((w_smp_prod + 32'sd32767) >>> 15)
                                         : 16'(w_smp_prod >>> 15);

    always_ff @(posedge i_clk) begin
        if (i_cmd.env_mul) begin
            r_env <= w_env_next;
        end
        if (i_cmd.load) begin
            r_sample     <= r_neg_use ? -w_smp_next : w_smp_next;
            r_symbol_end <= r_last;
        end
    end

    assign o_sample     = r_sample;
    assign o_symbol_end = r_symbol_end;

endmodule
